[src/b64sd_pkg.sv]
package b64sd_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharUscore = 8'h5F;
  localparam logic [7:0] CharPad    = 8'h3D;

  localparam logic [5:0] SextetLowerBase = 6'd26;
  localparam logic [5:0] SextetDigitBase = 6'd52;
  localparam logic [5:0] SextetPlus      = 6'd62;
  localparam logic [5:0] SextetSlash     = 6'd63;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // One decoded result as it travels to the output register.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_char;
    logic       end_mark;
  } result_t;

  // Map a character of either alphabet to its sextet.
  function automatic sextet_t sextet_of(logic [7:0] c);
    sextet_t    r;
    logic [7:0] diff;
    r    = '{valid: 1'b1, value: '0};
    diff = '0;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      diff    = c - CharUpperA;
      r.value = diff[5:0];
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      diff    = c - CharLowerA;
      r.value = diff[5:0] + SextetLowerBase;
    end else if (c >= CharZero && c <= CharNine) begin
      diff    = c - CharZero;
      r.value = diff[5:0] + SextetDigitBase;
    end else if (c == CharPlus || c == CharMinus) begin
      r.value = SextetPlus;
    end else if (c == CharSlash || c == CharUscore) begin
      r.value = SextetSlash;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

[src/b64sd_core.sv]
module b64sd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          in_char_i,
  input  logic                is_last_i,
  output logic                res_valid_o,
  output b64sd_pkg::result_t  res_o
);

  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;
  localparam logic [1:0] PhaseFourth = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [5:0] prev_q, prev_d;
  logic       stopped_q, stopped_d;
  logic       failed_q, failed_d;

  b64sd_pkg::sextet_t sx;
  logic               emit;
  logic               fresh_error;
  logic [7:0]         byte_val;

  always_comb begin
    sx          = b64sd_pkg::sextet_of(in_char_i);
    phase_d     = phase_q;
    prev_d      = prev_q;
    stopped_d   = stopped_q;
    failed_d    = failed_q;
    emit        = 1'b0;
    fresh_error = 1'b0;
    byte_val    = '0;
    if (!stopped_q && !failed_q) begin
      if (in_char_i == b64sd_pkg::CharPad) begin
        emit      = (phase_q == PhaseSecond);
        byte_val  = {prev_q, 2'b00};
        stopped_d = 1'b1;
      end else if (!sx.valid) begin
        failed_d    = 1'b1;
        fresh_error = 1'b1;
      end else begin
        case (phase_q)
          PhaseFirst: begin
            emit     = is_last_i;
            byte_val = {sx.value, 2'b00};
          end
          PhaseSecond: begin
            emit     = 1'b1;
            byte_val = {prev_q, sx.value[5:4]};
          end
          PhaseThird: begin
            emit     = 1'b1;
            byte_val = {prev_q[3:0], sx.value[5:2]};
          end
          PhaseFourth: begin
            emit     = 1'b1;
            byte_val = {prev_q[1:0], sx.value};
          end
          default: begin
            emit     = 1'b0;
            byte_val = '0;
          end
        endcase
        prev_d  = sx.value;
        phase_d = phase_q + 2'd1;
      end
    end

    res_valid_o    = emit || fresh_error || is_last_i;
    res_o.out_byte = emit ? byte_val : 8'h00;
    res_o.has_byte = emit;
    res_o.bad_char = failed_d;
    res_o.end_mark = is_last_i;

    // End of string: start the next one clean.
    if (is_last_i) begin
      phase_d   = PhaseFirst;
      prev_d    = '0;
      stopped_d = 1'b0;
      failed_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseFirst;
      prev_q    <= '0;
      stopped_q <= 1'b0;
      failed_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      prev_q    <= prev_d;
      stopped_q <= stopped_d;
      failed_q  <= failed_d;
    end
  end

  a_stop_fail_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (stopped_q || failed_q) && !is_last_i) |=>
      ($stable(phase_q) && $stable(prev_q)))
    else $error("state moved while decoding was stopped");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_last_i) |=>
      (phase_q == PhaseFirst && !stopped_q && !failed_q))
    else $error("state not cleared after last character");

  a_no_byte_when_halted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (stopped_q || failed_q)) |-> !res_o.has_byte)
    else $error("byte emitted after decoding ended");

endmodule

[src/b64sd_out_reg.sv]
module b64sd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  b64sd_pkg::result_t  res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output b64sd_pkg::result_t  res_o
);

  logic               valid_q, valid_d;
  b64sd_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: hold until replaced by a new result.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[src/base64_stream_decoder_unit.sv]
// Base64 stream decoder, one character per request.
// Input channel: in_valid_i / in_stall_o carry in_char_i and is_last_i; a
// request is taken at a rising edge with in_valid_i high and in_stall_o low.
// Both alphabets are accepted at once ('+' or '-' is 62, '/' or '_' is 63).
// Output channel: out_valid_o / out_stall_i carry out_byte_o, has_byte_o,
// bad_char_o and end_mark_o. A result appears for the 2nd, 3rd and 4th
// character of a group, for a lone trailing sextet, for the first invalid
// character, and always for the character marked is_last_i.
// Path: an accepted request waits in the input register, is decoded, and
// a result, if any, lands in the result register once that is free or
// being drained. Throughput: one character per cycle while out_stall_i
// does not hold a pending result, set by the single decode pass.
// Reset: clears group position, previous sextet, stop and error flags and
// both valid bits; no result is pending afterwards.
// Stall: while out_stall_i holds a pending result, the input register holds
// its character and in_stall_o rises once that register is occupied; a
// character that gives no result still passes as long as the result
// register is free or being drained.
module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       bad_char_o,
  output logic       end_mark_o
);

  // Input register stage
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       last_q;

  logic advance;     // the result register can take a new result
  logic accept;      // a request enters the input register
  logic step;        // the held character is decoded this cycle

  logic               res_valid;
  b64sd_pkg::result_t res;
  b64sd_pkg::result_t out_res;

  assign advance    = !(out_valid_o && out_stall_i);
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the character until it is decoded.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= in_char_i;
      last_q <= is_last_i;
    end
  end

  // Decode pass: sextet map, group state and byte assembly.
  b64sd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_char_i   (char_q),
    .is_last_i   (last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register: drop characters that yield nothing.
  b64sd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign out_byte_o = out_res.out_byte;
  assign has_byte_o = out_res.has_byte;
  assign bad_char_o = out_res.bad_char;
  assign end_mark_o = out_res.end_mark;

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o))
    else $error("input stalled with nothing held");

  a_held_item_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (in_valid_q && $stable(char_q) && $stable(last_q)))
    else $error("held character lost during stall");

  a_empty_result_is_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o && !end_mark_o) |-> bad_char_o)
    else $error("result without byte, end or error");

  a_zero_without_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> (out_byte_o == 8'h00))
    else $error("byte field not cleared");

endmodule
